// File: rtl/fol_pkg.sv
// ----------------------------------------------------------------------------
// fol_pkg
// Shared widths, controller state codes and the command bundle of the
// frequency ordered list.
// ----------------------------------------------------------------------------
package fol_pkg;

  localparam int unsigned KEY_W       = 8;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned HIT_COUNT_W = 16;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FIND = 3'b010,
    S_MOVE = 3'b100
  } state_e;

  typedef struct packed {
    logic load_key;
    logic find_en;
    logic move_en;
  } cmd_t;

endpackage

// File: rtl/fol_if.sv
// ----------------------------------------------------------------------------
// fol_in_if / fol_out_if
// Valid/ready channels carrying one lookup item and one result item.
// ----------------------------------------------------------------------------
interface fol_in_if;
  logic                     valid;
  logic                     ready;
  logic [fol_pkg::KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface fol_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [fol_pkg::POS_W-1:0]      old_position;
  logic [fol_pkg::POS_W-1:0]      new_position;
  logic [fol_pkg::HIT_COUNT_W-1:0] hit_count;

  modport source (output valid, output hit, output old_position, output new_position,
                  output hit_count, input ready);
  modport sink   (input valid, input hit, input old_position, input new_position,
                  input hit_count, output ready);
endinterface

// File: rtl/frequency_ordered_list_top.sv
// ----------------------------------------------------------------------------
// frequency_ordered_list_top
// Self-organizing list kept in access-count order (count method).
// Flow: an accepted item does its match in the find state, then its shift and
//   reinsert over the slot registers in the move state; a new item is taken
//   in the move state, not in find; move and new items wait if results back up.
// Reset: slots hold keys 1..ENTRIES with counts cleared; no item in flight.
// ----------------------------------------------------------------------------
module frequency_ordered_list_top #(
  parameter int unsigned ENTRIES    = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  fol_in_if.sink    in_ch,
  fol_out_if.source out_ch
);

  fol_pkg::cmd_t cmd;

  fol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .cmd_o      (cmd)
  );

  fol_datapath #(
    .ENTRIES   (ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .key_i         (in_ch.key),
    .hit_o         (out_ch.hit),
    .old_position_o(out_ch.old_position),
    .new_position_o(out_ch.new_position),
    .hit_count_o   (out_ch.hit_count)
  );

  a_accept_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> cmd.find_en)
    else $error("accepted item not followed by find");

  a_find_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.find_en |-> !in_ch.ready)
    else $error("input ready during find");

  a_move_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.move_en |=> out_ch.valid)
    else $error("move did not present a result");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.hit |-> (out_ch.hit_count == '0) &&
      (out_ch.old_position == '0) && (out_ch.new_position == '0))
    else $error("miss result carries nonzero fields");

endmodule

// File: rtl/fol_ctrl.sv
// ----------------------------------------------------------------------------
// fol_ctrl
// Sequencer: accept, find, move; owns the result valid flag.
// ----------------------------------------------------------------------------
module fol_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fol_pkg::cmd_t cmd_o
);

  fol_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == fol_pkg::S_IDLE) ||
                      ((state_q == fol_pkg::S_MOVE) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.load_key = accept;
  assign cmd_o.find_en  = (state_q == fol_pkg::S_FIND);
  assign cmd_o.move_en  = (state_q == fol_pkg::S_MOVE) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fol_pkg::S_IDLE: begin
        if (accept) state_d = fol_pkg::S_FIND;
      end
      fol_pkg::S_FIND: begin
        state_d = fol_pkg::S_MOVE;
      end
      fol_pkg::S_MOVE: begin
        if (out_free) state_d = accept ? fol_pkg::S_FIND : fol_pkg::S_IDLE;
      end
      default: begin
        state_d = fol_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.move_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fol_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/fol_datapath.sv
// ----------------------------------------------------------------------------
// fol_datapath
// Slot registers, parallel key match, saturating count, shifting reinsert
// and the result register.
// ----------------------------------------------------------------------------
module fol_datapath #(
  parameter int unsigned ENTRIES    = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fol_pkg::cmd_t                     cmd_i,
  input  logic [fol_pkg::KEY_W-1:0]         key_i,
  output logic                              hit_o,
  output logic [fol_pkg::POS_W-1:0]         old_position_o,
  output logic [fol_pkg::POS_W-1:0]         new_position_o,
  output logic [fol_pkg::HIT_COUNT_W-1:0]   hit_count_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [fol_pkg::KEY_W-1:0] keys_q   [ENTRIES];
  logic [COUNT_BITS-1:0]     counts_q [ENTRIES];

  logic [fol_pkg::KEY_W-1:0] key_q;
  logic                      found_q, found_d;
  logic [IDX_W-1:0]          pos_q, pos_d;
  logic [COUNT_BITS-1:0]     cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]     cur_cnt;
  logic [IDX_W-1:0]          dst;

  logic                           hit_q;
  logic [fol_pkg::POS_W-1:0]      old_pos_q;
  logic [fol_pkg::POS_W-1:0]      new_pos_q;
  logic [fol_pkg::HIT_COUNT_W-1:0] hit_cnt_q;

  // key match, lowest slot wins
  always_comb begin
    found_d = 1'b0;
    pos_d   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (keys_q[i] == key_q) begin
        found_d = 1'b1;
        pos_d   = IDX_W'(i);
      end
    end
    cur_cnt = counts_q[pos_d];
    cnt_d   = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
  end

  // first slot ahead whose count does not exceed the new count
  always_comb begin
    dst = pos_q;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if ((IDX_W'(i) < pos_q) && (counts_q[i] <= cnt_q)) dst = IDX_W'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) key_q <= key_i;
    if (cmd_i.find_en) begin
      found_q <= found_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
    if (cmd_i.move_en) begin
      hit_q     <= found_q;
      old_pos_q <= found_q ? fol_pkg::POS_W'(pos_q) : '0;
      new_pos_q <= found_q ? fol_pkg::POS_W'(dst) : '0;
      hit_cnt_q <= found_q ? fol_pkg::HIT_COUNT_W'(cnt_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        keys_q[i]   <= fol_pkg::KEY_W'(i + 1);
        counts_q[i] <= '0;
      end
    end else if (cmd_i.move_en && found_q) begin
      if (dst == '0) begin
        keys_q[0]   <= key_q;
        counts_q[0] <= cnt_q;
      end
      for (int i = 1; i < ENTRIES; i++) begin
        if (IDX_W'(i) == dst) begin
          keys_q[i]   <= key_q;
          counts_q[i] <= cnt_q;
        end else if ((IDX_W'(i) > dst) && (IDX_W'(i) <= pos_q)) begin
          keys_q[i]   <= keys_q[i-1];
          counts_q[i] <= counts_q[i-1];
        end
      end
    end
  end

  assign hit_o          = hit_q;
  assign old_position_o = old_pos_q;
  assign new_position_o = new_pos_q;
  assign hit_count_o    = hit_cnt_q;

endmodule

// File: tb/sv/frequency_ordered_list_top_tb.sv
// ----------------------------------------------------------------------------
// frequency_ordered_list_top_tb
// Drives lookup keys into the frequency ordered list and checks every
// result item against a shadow copy of the list, kept in count order and
// updated on each accepted lookup. Covers hits at the front and at the
// tail, misses, ties and output back-pressure.
// ----------------------------------------------------------------------------
module frequency_ordered_list_top_tb;

  localparam int unsigned LIST_ENTRIES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam logic [fol_pkg::HIT_COUNT_W-1:0] COUNT_MAX = {fol_pkg::HIT_COUNT_W{1'b1}};

  typedef struct packed {
    logic                            hit;
    logic [fol_pkg::POS_W-1:0]       old_position;
    logic [fol_pkg::POS_W-1:0]       new_position;
    logic [fol_pkg::HIT_COUNT_W-1:0] hit_count;
  } lookup_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fol_in_if  in_ch ();
  fol_out_if out_ch ();

  frequency_ordered_list_top #(
    .ENTRIES   (LIST_ENTRIES),
    .COUNT_BITS(fol_pkg::HIT_COUNT_W)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #1 clk_i = ~clk_i;

  logic [fol_pkg::KEY_W-1:0]       shadow_keys   [LIST_ENTRIES];
  logic [fol_pkg::HIT_COUNT_W-1:0] shadow_counts [LIST_ENTRIES];
  lookup_result_t                  pending_results[$];
  lookup_result_t                  check_want;

  int  mismatches   = 0;
  int  results_seen = 0;
  int  cycle_count  = 0;
  bit  tx_idle_en   = 1'b0;
  bit  rx_idle_en   = 1'b0;
  int  rx_hold_req  = 0;
  int  rx_hold_cnt  = 0;
  int  rx_burst_cnt = 0;

  // count-method reorder: bump, then move ahead of every entry with count <= new
  task automatic predict_lookup(input logic [fol_pkg::KEY_W-1:0] key,
                                output lookup_result_t res);
    int                              pos;
    int                              dst;
    bit                              found;
    bit                              placed;
    logic [fol_pkg::HIT_COUNT_W-1:0] cnt;
    found = 1'b0;
    pos   = 0;
    res   = '0;
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      if (!found && shadow_keys[i] == key) begin
        pos   = i;
        found = 1'b1;
      end
    end
    if (found) begin
      cnt = shadow_counts[pos];
      if (cnt != COUNT_MAX) cnt = cnt + fol_pkg::HIT_COUNT_W'(1);
      dst = 0;
      if (pos != 0) begin
        dst    = pos;
        placed = 1'b0;
        for (int i = 0; i < pos; i++) begin
          if (!placed && shadow_counts[i] <= cnt) begin
            dst    = i;
            placed = 1'b1;
          end
        end
        for (int i = pos; i > dst; i--) begin
          shadow_keys[i]   = shadow_keys[i-1];
          shadow_counts[i] = shadow_counts[i-1];
        end
        shadow_keys[dst] = key;
      end
      shadow_counts[dst] = cnt;
      res.hit          = 1'b1;
      res.old_position = fol_pkg::POS_W'(pos);
      res.new_position = fol_pkg::POS_W'(dst);
      res.hit_count    = cnt;
    end
  endtask

  task automatic send_lookup(input logic [fol_pkg::KEY_W-1:0] key);
    lookup_result_t want;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.key   <= key;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_lookup(key, want);
    pending_results.push_back(want);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [fol_pkg::KEY_W-1:0] keys [$];
    keys = '{8'd1, 8'd8, 8'd0, 8'd255, 8'd9, 8'd128, 8'd2, 8'd3, 8'd4,
             8'd5, 8'd6, 8'd7, 8'd1, 8'd8, 8'd8, 8'd8, 8'd1, 8'd1, 8'd170, 8'd85};
    foreach (keys[i]) send_lookup(keys[i]);
    wait_drained();
  endtask

  // output held off while input keeps coming: block fills and stalls its input
  task automatic test_backpressure();
    rx_hold_req = 200;
    for (int n = 0; n < 24; n++)
      send_lookup(fol_pkg::KEY_W'($urandom_range(1, LIST_ENTRIES)));
    wait_drained();
  endtask

  task automatic test_random_lookups(input int items);
    int                        pick;
    logic [fol_pkg::KEY_W-1:0] key;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int n = 0; n < items; n++) begin
      if (n == items * 3 / 4) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      key = fol_pkg::KEY_W'($urandom_range(1, 3));
      else if (pick < 75) key = fol_pkg::KEY_W'($urandom_range(1, LIST_ENTRIES));
      else if (pick < 82) key = ($urandom_range(0, 2) == 0) ? 8'd0 :
                                ($urandom_range(0, 1) == 0) ? 8'd9 : 8'd255;
      else                key = fol_pkg::KEY_W'($urandom_range(0, 255));
      send_lookup(key);
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_hold_req != 0) begin
        rx_hold_cnt = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold_cnt > 0) begin
        rx_hold_cnt--;
        out_ch.ready <= 1'b0;
      end else if (rx_idle_en && rx_burst_cnt > 0) begin
        rx_burst_cnt--;
        out_ch.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        rx_burst_cnt = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d with no lookup pending: hit=%0b old=%0d new=%0d count=%0d",
                   results_seen, out_ch.hit, out_ch.old_position, out_ch.new_position,
                   out_ch.hit_count);
        mismatches++;
      end else begin
        check_want = pending_results.pop_front();
        if (out_ch.hit !== check_want.hit ||
            out_ch.old_position !== check_want.old_position ||
            out_ch.new_position !== check_want.new_position ||
            out_ch.hit_count !== check_want.hit_count) begin
          if (mismatches < 10)
            $display("result %0d: want hit=%0b old=%0d new=%0d count=%0d, got %0b %0d %0d %0d",
                     results_seen, check_want.hit, check_want.old_position,
                     check_want.new_position, check_want.hit_count, out_ch.hit,
                     out_ch.old_position, out_ch.new_position, out_ch.hit_count);
          mismatches++;
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.key    <= '0;
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      shadow_keys[i]   = fol_pkg::KEY_W'(i + 1);
      shadow_counts[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random_lookups(1600);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
